/* rtl/bmf_pkg.sv */
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared constants, types and state codes of the 5x5 box mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int CFG_W  = 11;                          // configuration register width
    localparam int CW     = $clog2(MAX_WIDTH);           // column index
    localparam int WW     = CW + 1;                      // width value, 1..MAX_WIDTH
    localparam int RW     = $clog2(MAX_HEIGHT + 2);      // row position incl. drain rows
    localparam int NBANK  = 4;
    localparam int BANK_W = 2;
    localparam int PIX_W  = 8;
    localparam int CSUM_W = 11;                          // column sum, up to 5*255
    localparam int WSUM_W = 13;                          // window sum, up to 25*255 + 12
    localparam int CNT_W  = 5;                           // pixel count, 1..25
    localparam int NR_W   = 3;                           // rows or columns, 1..5
    localparam int OIDX_W = 10;                          // output row / column field

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_START,
        ST_DIV,
        ST_OUT
    } bmf_state_t;

    typedef struct packed {
        logic accept;       // item taken: latch it and start the line reads
        logic calc;         // update column sums, line store and position
        logic div_start;    // pick up the next result and start the divider
        logic next_result;  // current result taken
    } bmf_cmd_t;

    typedef struct packed {
        logic drop_item;    // drain step outside the drain: no effect
        logic no_result;    // this item gives no result (valid in ST_CALC)
        logic last_result;  // current result is the last of the item
        logic div_done;
    } bmf_status_t;

endpackage

/* rtl/box_mean_filter_5x5_unit.sv */
// ----------------------------------------------------------------------------
// box_mean_filter_5x5_unit
// Streaming 5x5 box mean of 8-bit grey pixels, window clipped at the borders.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one item per pixel in raster order with
// action = 0, then 2*width drain items (action = 1) to flush the last two
// rows. A drain item outside the drain is taken and has no effect; a pixel
// during the drain starts a new frame.
// Output channel (out_valid/out_ready): each item gives 0 to 3 results, the
// pixel two rows and two columns back, plus the last two columns of that row
// at the end of a row; last_of_item marks the final one.
// An item that gives no result passes only through the accept and calc
// states. Each result adds a set-up state, the one-bit-a-cycle divider and
// a wait in the output register until taken. Items are handled one at a
// time; in_ready is high only between items.
// A stalled receiver holds the result in the output register and the block
// takes no new item until it is gone.
// Reset sets width 640, height 480 and starts a fresh frame. A write to
// either size register also restarts the frame; the line store keeps data.
// ----------------------------------------------------------------------------
module box_mean_filter_5x5_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [bmf_pkg::PIX_W-1:0]     pixel_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bmf_pkg::PIX_W-1:0]     pixel_out,
    output logic [bmf_pkg::OIDX_W-1:0]    out_row,
    output logic [bmf_pkg::OIDX_W-1:0]    out_col,
    output logic                          last_of_item,
    output logic                          frame_end
);
    import bmf_pkg::*;

    bmf_cmd_t    cmd;
    bmf_status_t status;

    bmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bmf_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .pixel_in     (pixel_in),
        .pixel_out    (pixel_out),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_item (last_of_item),
        .frame_end    (frame_end),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

/* rtl/bmf_ram.sv */
// ----------------------------------------------------------------------------
// bmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/bmf_div.sv */
// ----------------------------------------------------------------------------
// bmf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmf_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bmf_pkg::WSUM_W-1:0]    dividend,
    input  logic [bmf_pkg::CNT_W-1:0]     divisor,
    output logic [bmf_pkg::WSUM_W-1:0]    quotient,
    output logic                          done
);
    import bmf_pkg::*;

    localparam int ITER_W = $clog2(WSUM_W + 1);

    logic [WSUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W+1:0]  trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[WSUM_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            iter_next = ITER_W'(WSUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {2'b00, dsr_reg})
            begin
                rem_next = (CNT_W+1)'(trial - {2'b00, dsr_reg});
                quo_next = {quo_reg[WSUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = (CNT_W+1)'(trial);
                quo_next = {quo_reg[WSUM_W-2:0], 1'b0};
            end
            iter_next = iter_reg - 1'b1;
            if (iter_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

/* rtl/bmf_ctrl.sv */
// ----------------------------------------------------------------------------
// bmf_ctrl
// Sequencer: take item, update sums, then divide and hand out each result.
// ----------------------------------------------------------------------------
module bmf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  bmf_pkg::bmf_status_t  status,
    output bmf_pkg::bmf_cmd_t     cmd
);
    import bmf_pkg::*;

    bmf_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !status.drop_item)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = status.no_result ? ST_IDLE : ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = status.last_result ? ST_IDLE : ST_START;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        cmd             = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_CALC:
            begin
                cmd.calc = 1'b1;
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
            end
            ST_DIV:
            begin
            end
            ST_OUT:
            begin
                out_valid       = 1'b1;
                cmd.next_result = out_ready;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/bmf_datapath.sv */
// ----------------------------------------------------------------------------
// bmf_datapath
// Line store banks, column sums, positions, window sum and output registers.
// ----------------------------------------------------------------------------
module bmf_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          action,
    input  logic [bmf_pkg::PIX_W-1:0]     pixel_in,
    output logic [bmf_pkg::PIX_W-1:0]     pixel_out,
    output logic [bmf_pkg::OIDX_W-1:0]    out_row,
    output logic [bmf_pkg::OIDX_W-1:0]    out_col,
    output logic                          last_of_item,
    output logic                          frame_end,
    input  bmf_pkg::bmf_cmd_t             cmd,
    output bmf_pkg::bmf_status_t          status
);
    import bmf_pkg::*;

    // configuration
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [WW-1:0]    w_eff;
    logic [RW-1:0]    h_eff;

    // frame position
    logic [RW-1:0]    row_reg, row_next;
    logic [CW-1:0]    col_reg, col_next;
    logic             draining_reg, draining_next;
    logic [CSUM_W-1:0] csum_reg [5];
    logic [CSUM_W-1:0] csum_next [5];

    // latched item
    logic [RW-1:0]    vr_reg;
    logic [CW-1:0]    c_reg;
    logic [PIX_W-1:0] px_reg;
    logic [NR_W-1:0]  nrows_reg;
    logic [WW-1:0]    ocol_reg [3];
    logic [1:0]       nres_reg;
    logic [1:0]       k_reg;

    // output payload
    logic [OIDX_W-1:0] orow_out_reg, ocol_out_reg;
    logic              last_out_reg, fend_out_reg;

    // line store
    logic [PIX_W-1:0] rd_data [NBANK];
    logic             restart_now;
    logic [RW-1:0]    vr_base;
    logic [CW-1:0]    c_base, c_clamp;

    // calc stage
    logic [RW-1:0]     orow, rlo, rhi, rrow;
    logic              has_rows, emit_ok;
    logic [CSUM_W-1:0] newsum;
    logic [WW-1:0]     cw, wl;
    logic [WW-1:0]     ocol_c [3];
    logic [1:0]        nres_c;

    // result stage
    logic [WW-1:0]     ocol, lo, hi, wcol;
    logic [WSUM_W-1:0] wsum, dividend;
    logic [NR_W-1:0]   ncols;
    logic [CNT_W-1:0]  count;
    logic [WSUM_W-1:0] quotient;
    logic              div_done;

    // clamp register values to 1..max
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        if (height_reg == '0)
            h_eff = RW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = RW'(MAX_HEIGHT);
        else
            h_eff = RW'(height_reg);
    end

    // position at accept, with restart when a pixel breaks into the drain
    always_comb
    begin
        restart_now = !action && draining_reg;
        vr_base     = restart_now ? '0 : row_reg;
        c_base      = restart_now ? '0 : col_reg;
        c_clamp     = (WW'(c_base) >= w_eff) ? CW'(w_eff - 1'b1) : c_base;
    end

    for (genvar b = 0; b < NBANK; b++)
    begin : g_bank
        bmf_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .clk   (clk),
            .we    (cmd.calc && (vr_reg < h_eff) && (vr_reg[BANK_W-1:0] == BANK_W'(b))),
            .waddr (c_reg),
            .wdata (px_reg),
            .re    (cmd.accept),
            .raddr (c_clamp),
            .rdata (rd_data[b])
        );
    end

    // vertical sum of the new column and the result columns of this item
    always_comb
    begin
        has_rows = vr_reg >= RW'(2);
        orow     = RW'(vr_reg - RW'(2));
        rlo      = (orow >= RW'(2)) ? RW'(orow - RW'(2)) : '0;
        rhi      = (orow + RW'(2) <= h_eff - 1'b1) ? RW'(orow + RW'(2)) : RW'(h_eff - 1'b1);
        emit_ok  = has_rows && (orow < h_eff);
        newsum   = '0;
        if (has_rows)
        begin
            for (int d = 1; d <= NBANK; d++)
            begin
                rrow = RW'(vr_reg - RW'(d));
                if (vr_reg >= RW'(d) && rrow >= rlo && rrow <= rhi)
                    newsum = newsum + CSUM_W'(rd_data[rrow[BANK_W-1:0]]);
            end
            if (rhi == vr_reg)
                newsum = newsum + CSUM_W'(px_reg);
        end
        else
        begin
            rrow = '0;
        end

        cw        = WW'(c_reg);
        wl        = WW'(w_eff - 1'b1);
        ocol_c[0] = '0;
        ocol_c[1] = '0;
        ocol_c[2] = '0;
        nres_c    = 2'd0;
        if (emit_ok)
        begin
            if (cw >= WW'(2))
            begin
                ocol_c[0] = WW'(cw - WW'(2));
                nres_c    = 2'd1;
            end
            if (cw == wl)
            begin
                if (cw >= WW'(1))
                begin
                    ocol_c[nres_c] = WW'(cw - WW'(1));
                    nres_c         = nres_c + 2'd1;
                end
                ocol_c[nres_c] = cw;
                nres_c         = nres_c + 2'd1;
            end
        end
    end

    // window sum and count of the current result
    always_comb
    begin
        ocol  = ocol_reg[k_reg];
        lo    = (ocol >= WW'(2)) ? WW'(ocol - WW'(2)) : '0;
        hi    = (ocol + WW'(2) <= WW'(w_eff - 1'b1)) ? WW'(ocol + WW'(2)) : WW'(w_eff - 1'b1);
        wsum  = '0;
        wcol  = '0;
        for (int j = 0; j < 5; j++)
        begin
            wcol = WW'(WW'(c_reg) - WW'(j));
            if (WW'(c_reg) >= WW'(j) && wcol >= lo && wcol <= hi)
                wsum = wsum + WSUM_W'(csum_reg[j]);
        end
        ncols    = NR_W'(hi - lo + 1'b1);
        count    = CNT_W'(ncols * nrows_reg);
        dividend = wsum + WSUM_W'(count >> 1);
    end

    bmf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (count),
        .quotient (quotient),
        .done     (div_done)
    );

    // next state of position, drain flag and column sums
    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        draining_next = draining_reg;
        for (int i = 0; i < 5; i++)
            csum_next[i] = csum_reg[i];
        if (cfg_we)
        begin
            row_next      = '0;
            col_next      = '0;
            draining_next = 1'b0;
            for (int i = 0; i < 5; i++)
                csum_next[i] = '0;
        end
        else if (cmd.accept && restart_now)
        begin
            row_next      = '0;
            col_next      = '0;
            draining_next = 1'b0;
            for (int i = 0; i < 5; i++)
                csum_next[i] = '0;
        end
        else if (cmd.calc)
        begin
            for (int i = 4; i > 0; i--)
                csum_next[i] = csum_reg[i-1];
            csum_next[0] = newsum;
            if (WW'(c_reg) + 1'b1 >= w_eff)
            begin
                col_next = '0;
                row_next = RW'(vr_reg + 1'b1);
                if (RW'(vr_reg + 1'b1) == h_eff)
                    draining_next = 1'b1;
                if ((RW+1)'(vr_reg) + 1'b1 >= (RW+1)'(h_eff) + (RW+1)'(2))
                begin
                    row_next      = '0;
                    draining_next = 1'b0;
                end
            end
            else
            begin
                col_next = CW'(c_reg + 1'b1);
                row_next = vr_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= CFG_W'(640);
            height_reg   <= CFG_W'(480);
            row_reg      <= '0;
            col_reg      <= '0;
            draining_reg <= 1'b0;
            for (int i = 0; i < 5; i++)
                csum_reg[i] <= '0;
            nres_reg     <= '0;
            k_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default:          ;
                endcase
            end
            row_reg      <= row_next;
            col_reg      <= col_next;
            draining_reg <= draining_next;
            for (int i = 0; i < 5; i++)
                csum_reg[i] <= csum_next[i];
            if (cmd.calc)
            begin
                nres_reg <= nres_c;
                k_reg    <= '0;
            end
            else if (cmd.next_result)
            begin
                k_reg <= k_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            vr_reg <= vr_base;
            c_reg  <= c_clamp;
            px_reg <= pixel_in;
        end
        if (cmd.calc)
        begin
            nrows_reg <= NR_W'(rhi - rlo + 1'b1);
            for (int i = 0; i < 3; i++)
                ocol_reg[i] <= ocol_c[i];
        end
        if (cmd.div_start)
        begin
            orow_out_reg <= OIDX_W'(orow);
            ocol_out_reg <= OIDX_W'(ocol);
            last_out_reg <= (k_reg == nres_reg - 2'd1);
            fend_out_reg <= (orow == RW'(h_eff - 1'b1)) && (ocol == WW'(w_eff - 1'b1));
        end
    end

    always_comb
    begin
        status.drop_item   = action && !draining_reg;
        status.no_result   = (nres_c == 2'd0);
        status.last_result = last_out_reg;
        status.div_done    = div_done;
    end

    assign pixel_out    = PIX_W'(quotient);
    assign out_row      = orow_out_reg;
    assign out_col      = ocol_out_reg;
    assign last_of_item = last_out_reg;
    assign frame_end    = fend_out_reg;

endmodule

/* rtl/bmf_checker.sv */
// ----------------------------------------------------------------------------
// bmf_checker
// Port-level checks of the box mean filter, bound to the top level.
// ----------------------------------------------------------------------------
module bmf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bmf_pkg::PIX_W-1:0]     pixel_out,
    input logic                          last_of_item,
    input logic                          frame_end
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out))
        else $error("result changed while stalled");

    // one item at a time: no intake while a result is shown
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    // bottom-right pixel ends its item
    a_fend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> last_of_item)
        else $error("frame end not last of item");

    // after a result is taken mid-item, no intake next cycle
    a_more: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_item |=> !in_ready)
        else $error("item ended before its last result");

endmodule

bind box_mean_filter_5x5_unit bmf_checker u_bmf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_out    (pixel_out),
    .last_of_item (last_of_item),
    .frame_end    (frame_end)
);

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 5x5 box mean filter. Frames of random
// pixels with drain steps are streamed through, with random idling on both
// channels. Each result is checked field by field against a built-in
// line-buffer model of the filter.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bmf_pkg::*;

    localparam int LIMIT_CYCLES = 200_000;
    localparam int SETTLE       = 40;

    typedef struct {
        logic [PIX_W-1:0]  mean;
        logic [OIDX_W-1:0] row;
        logic [OIDX_W-1:0] col;
        logic              last;
        logic              fend;
    } mean_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 action;
    logic [PIX_W-1:0]     pixel_in;
    logic                 out_valid;
    logic                 out_ready;
    logic [PIX_W-1:0]     pixel_out;
    logic [OIDX_W-1:0]    out_row;
    logic [OIDX_W-1:0]    out_col;
    logic                 last_of_item;
    logic                 frame_end;

    // filter model state
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [PIX_W-1:0]  rows_mem [0:4*MAX_WIDTH-1];
    int                col_sum [0:4];
    int                row_pos;
    int                col_pos;
    bit                draining;

    mean_result_t      mean_q[$];
    bit                failed;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                hold_left;
    int                cycles;
    int                items_sent;

    box_mean_filter_5x5_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .pixel_in     (pixel_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_out    (pixel_out),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_item (last_of_item),
        .frame_end    (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= LIMIT_CYCLES)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------
    function automatic int clamp_size(logic [CFG_W-1:0] v, int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic void frame_restart();
        row_pos  = 0;
        col_pos  = 0;
        draining = 0;
        for (int i = 0; i < 5; i++)
            col_sum[i] = 0;
    endfunction

    function automatic void push_mean(int orow, int ocol, int c, int w, int nrows, int h);
        int lo;
        int hi;
        int sum;
        int cnt;
        int back;
        mean_result_t r;
        lo  = (ocol >= 2) ? ocol - 2 : 0;
        hi  = (ocol + 2 <= w - 1) ? ocol + 2 : w - 1;
        sum = 0;
        for (int col = lo; col <= hi; col++)
        begin
            back = c - col;
            if (back >= 0 && back < 5)
                sum += col_sum[back];
        end
        cnt    = (hi - lo + 1) * nrows;
        r.mean = PIX_W'((sum + cnt / 2) / cnt);
        r.row  = OIDX_W'(orow);
        r.col  = OIDX_W'(ocol);
        r.last = 1'b0;
        r.fend = (orow == h - 1 && ocol == w - 1);
        mean_q.push_back(r);
    endfunction

    function automatic void filter_step(logic act, logic [PIX_W-1:0] px);
        int w;
        int h;
        int vr;
        int c;
        int orow;
        int rlo;
        int rhi;
        int newsum;
        int n0;
        w  = clamp_size(width_reg, MAX_WIDTH);
        h  = clamp_size(height_reg, MAX_HEIGHT);
        n0 = mean_q.size();
        if (!act && draining)
            frame_restart();
        if (act && !draining)
            return;
        vr = row_pos;
        c  = col_pos;
        if (c >= w)
            c = w - 1;
        newsum = 0;
        if (vr >= 2)
        begin
            orow = vr - 2;
            rlo  = (orow >= 2) ? orow - 2 : 0;
            rhi  = (orow + 2 <= h - 1) ? orow + 2 : h - 1;
            for (int r = rlo; r <= rhi; r++)
            begin
                if (r == vr)
                    newsum += px;
                else
                    newsum += rows_mem[((r & 3) * MAX_WIDTH + c) & (4 * MAX_WIDTH - 1)];
            end
            for (int i = 4; i > 0; i--)
                col_sum[i] = col_sum[i-1];
            col_sum[0] = newsum & 'h7FF;
            if (orow < h)
            begin
                if (c >= 2)
                    push_mean(orow, c - 2, c, w, rhi - rlo + 1, h);
                if (c == w - 1)
                begin
                    if (c >= 1)
                        push_mean(orow, c - 1, c, w, rhi - rlo + 1, h);
                    push_mean(orow, c, c, w, rhi - rlo + 1, h);
                end
                if (mean_q.size() > n0)
                    mean_q[mean_q.size()-1].last = 1'b1;
            end
        end
        else
        begin
            for (int i = 4; i > 0; i--)
                col_sum[i] = col_sum[i-1];
            col_sum[0] = 0;
        end
        if (vr < h)
            rows_mem[((vr & 3) * MAX_WIDTH + c) & (4 * MAX_WIDTH - 1)] = px;
        c++;
        if (c >= w)
        begin
            c = 0;
            vr++;
            if (vr == h)
                draining = 1;
            if (vr >= h + 2)
            begin
                vr       = 0;
                draining = 0;
            end
        end
        row_pos = vr & 'h7FF;
        col_pos = c & 'h3FF;
    endfunction

    // ------------------------------------------------------------------------
    // receive side
    // ------------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        mean_result_t e;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (mean_q.size() == 0)
                begin
                    $error("result with nothing expected: row %0d col %0d", out_row, out_col);
                    failed = 1;
                end
                else
                begin
                    e = mean_q.pop_front();
                    if (pixel_out !== e.mean)
                    begin
                        $error("pixel_out: expected %0d, got %0d", e.mean, pixel_out);
                        failed = 1;
                    end
                    if (out_row !== e.row)
                    begin
                        $error("out_row: expected %0d, got %0d", e.row, out_row);
                        failed = 1;
                    end
                    if (out_col !== e.col)
                    begin
                        $error("out_col: expected %0d, got %0d", e.col, out_col);
                        failed = 1;
                    end
                    if (last_of_item !== e.last)
                    begin
                        $error("last_of_item: expected %0d, got %0d", e.last, last_of_item);
                        failed = 1;
                    end
                    if (frame_end !== e.fend)
                    begin
                        $error("frame_end: expected %0d, got %0d", e.fend, frame_end);
                        failed = 1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // send side
    // ------------------------------------------------------------------------
    task automatic send_item(logic act, logic [PIX_W-1:0] px);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        action   = act;
        pixel_in = px;
        do
            @(posedge clk);
        while (!in_ready);
        filter_step(act, px);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (mean_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_size(logic idx, logic [CFG_W-1:0] val);
        wait_idle();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        frame_restart();
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // full frame, optional stray drain steps inside, drain cut short if asked
    task automatic run_frame(int w, int h, bit noise, int drain_steps);
        for (int i = 0; i < w * h; i++)
        begin
            if (noise && $urandom_range(9) == 0)
                send_item(1'b1, rand_pixel());
            send_item(1'b0, rand_pixel());
        end
        for (int i = 0; i < drain_steps; i++)
            send_item(1'b1, rand_pixel());
    endtask

    task automatic set_size(int w, int h);
        write_size(REG_IMAGE_WIDTH, CFG_W'(w));
        write_size(REG_IMAGE_HEIGHT, CFG_W'(h));
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_small_frames();
        set_size(5, 5);
        // drain cut short, so the next frame's first pixel abandons it
        for (int i = 0; i < 25; i++)
            send_item(1'b0, (i % 2) ? 8'hFF : 8'h00);
        for (int i = 0; i < 3; i++)
            send_item(1'b1, 8'hFF);
        // stray drain steps in mid-frame
        run_frame(5, 5, 1'b1, 10);
        set_size(1, 1);
        run_frame(1, 1, 1'b0, 2);
        set_size(2, 3);
        run_frame(2, 3, 1'b0, 4);
    endtask

    task automatic test_size_extremes();
        // zero acts as 1, oversize acts as the maximum; the tall and the
        // wide frame are left unfinished and restarted by the next write
        set_size(0, 0);
        run_frame(1, 1, 1'b0, 2);
        set_size(0, 2047);
        for (int i = 0; i < 12; i++)
            send_item(1'b0, rand_pixel());
        set_size(2047, 3);
        for (int i = 0; i < 12; i++)
            send_item(1'b0, rand_pixel());
    endtask

    task automatic test_random_frames(int n_items);
        int w;
        int h;
        int start;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            set_size(w, h);
            repeat ($urandom_range(1, 2))
            begin
                if ($urandom_range(4) == 0)
                    run_frame(w, h, 1'b1, $urandom_range(2 * w - 1));
                else
                    run_frame(w, h, 1'b0, 2 * w);
            end
        end
    endtask

    task automatic test_output_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_size(5, 3);
        hold_left = 400;
        run_frame(5, 3, 1'b0, 10);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_IMAGE_WIDTH;
        cfg_data       = '0;
        in_valid       = 1'b0;
        action         = 1'b0;
        pixel_in       = '0;
        failed         = 0;
        hold_left      = 0;
        items_sent     = 0;
        send_idle_pct  = 35;
        recv_stall_pct = 61;
        width_reg      = CFG_W'(640);
        height_reg     = CFG_W'(480);
        for (int i = 0; i < 4 * MAX_WIDTH; i++)
            rows_mem[i] = '0;
        frame_restart();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_small_frames();
        send_idle_pct  = 61;
        recv_stall_pct = 35;
        test_random_frames(20);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_size_extremes();
        test_output_stall();

        wait_idle();
        if (!failed)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
